/* hdl/acam_pkg.sv */
// Package with the shared types and constants of the anchored Aho-Corasick matcher.
package acam_pkg;

  typedef enum logic [1:0] {
    OP_NODE = 2'd0,
    OP_EDGE = 2'd1,
    OP_PAT  = 2'd2,
    OP_TEXT = 2'd3
  } op_e;

  localparam int unsigned NODE_W  = 62;
  localparam int unsigned EDGE_W  = 24;
  localparam int unsigned PAT_W   = 27;
  localparam logic [7:0]  CASE_BIT = 8'd32;

  typedef struct packed {
    op_e         op;
    logic [11:0] addr;
    logic [63:0] word;
    logic [7:0]  text_byte;
    logic        ignore_case;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] match_code;
  } out_item_t;

  // Bit 5 toggle for ASCII letters, zero for everything else.
  function automatic logic [7:0] fold_mask(input logic [7:0] c);
    logic letter;
    letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    return letter ? CASE_BIT : 8'd0;
  endfunction

endpackage

/* hdl/acam_in_if.sv */
// Input channel interface: valid, ready and one input item.
interface acam_in_if;
  import acam_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/acam_out_if.sv */
// Output channel interface: valid, ready and one result item.
interface acam_out_if;
  import acam_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/acam_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module acam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/aho_corasick_anchored_matcher.sv */
// Top level of the anchored Aho-Corasick matcher: sequencer around three table memories.
//
//   channel | dir | handshake    | item
//   in_i    | in  | valid/ready  | op, addr, word, text_byte, ignore_case, last_byte
//   out_o   | out | valid/ready  | match_code (only after a text byte marked last)
//
// A load item writes its table in the accept cycle, and the block stays ready.
// A text byte reads its current node, then the target node when it moves, and
// does one read per failure hop, per edge probe (a range check can fail before
// any read) and per pattern entry scanned; each step is one memory read.
// Reset puts the walk at node 1 with position and best hits cleared; the
// tables are not cleared. The result sits in an output register, so a stalled
// sink only holds the block when a second result is ready to be written.
module aho_corasick_anchored_matcher #(
  parameter int unsigned NODE_COUNT    = 1024,
  parameter int unsigned EDGE_COUNT    = 4096,
  parameter int unsigned PATTERN_COUNT = 1024,
  parameter int unsigned MAX_TEXT_LEN  = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  acam_in_if.sink         in_i,
  acam_out_if.source      out_o
);
  import acam_pkg::*;

  localparam int unsigned NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned EAW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int unsigned PAW = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;

  // One-hot sequencer states. NRD/ERD/N2RD/PRD present a read address;
  // the matching EV state sees the memory data.
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_NRD  = 10'b0000000010,
    S_NEV  = 10'b0000000100,
    S_ERD  = 10'b0000001000,
    S_EEV  = 10'b0000010000,
    S_N2RD = 10'b0000100000,
    S_N2EV = 10'b0001000000,
    S_PRD  = 10'b0010000000,
    S_PEV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] node_q, node_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  c_q, c_d;
  logic [7:0]  fm_q, fm_d;
  logic        last_q, last_d;
  logic [16:0] hops_q, hops_d;
  logic        nvld_q, nvld_d;
  logic [15:0] out_q, out_d;
  logic [7:0]  deg_q, deg_d;
  logic [7:0]  low_q, low_d;
  logic        rng_q, rng_d;
  logic [15:0] fail_q, fail_d;
  logic        pass_q, pass_d;
  logic [7:0]  k_q, k_d;
  logic [16:0] eidx_q, eidx_d;
  logic [12:0] pidx_q, pidx_d;
  logic [7:0]  blen_q [4];
  logic [7:0]  blen_d [4];
  logic [15:0] bcode_q [4];
  logic [15:0] bcode_d [4];
  logic        ovalid_q, ovalid_d;
  logic [15:0] ocode_q, ocode_d;

  logic              in_acc;
  logic              node_we, edge_we, pat_we;
  logic [NODE_W-1:0] node_rdata, nd;
  logic [EDGE_W-1:0] edge_rdata;
  logic [PAT_W-1:0]  pat_rdata;

  assign in_acc  = in_i.valid && in_i.ready;
  assign node_we = in_acc && (in_i.data.op == OP_NODE) && (32'(in_i.data.addr) < NODE_COUNT);
  assign edge_we = in_acc && (in_i.data.op == OP_EDGE) && (32'(in_i.data.addr) < EDGE_COUNT);
  assign pat_we  = in_acc && (in_i.data.op == OP_PAT)
                   && (32'(in_i.data.addr) < PATTERN_COUNT);

  acam_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT), .AW(NAW)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NAW'(in_i.data.addr)),
    .wdata_i (in_i.data.word[NODE_W-1:0]),
    .raddr_i (NAW'(node_q)),
    .rdata_o (node_rdata)
  );

  // The edge index is chosen in the same cycle that reads it, so the next
  // index goes straight to the memory.
  acam_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_COUNT), .AW(EAW)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (EAW'(in_i.data.addr)),
    .wdata_i (in_i.data.word[EDGE_W-1:0]),
    .raddr_i (EAW'(eidx_d)),
    .rdata_o (edge_rdata)
  );

  acam_ram #(.WIDTH(PAT_W), .DEPTH(PATTERN_COUNT), .AW(PAW)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PAW'(in_i.data.addr)),
    .wdata_i (in_i.data.word[PAT_W-1:0]),
    .raddr_i (PAW'(pidx_q)),
    .rdata_o (pat_rdata)
  );

  // A node index beyond the table reads as an empty node.
  assign nd = nvld_q ? node_rdata : '0;

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = ovalid_q;
  assign out_o.data.match_code = ocode_q;

  always_comb begin
    logic [7:0]  cc;
    logic [8:0]  hi;
    logic [16:0] ridx, lidx;
    logic        in_rng;
    logic        pass_fail;
    logic        miss;
    logic [15:0] miss_fail;
    logic        hit;
    logic [15:0] hit_tgt;
    logic [7:0]  plen;
    logic [15:0] pcode;
    logic        pfs, pae, plast;
    logic [15:0] res;

    state_d  = state_q;
    node_d   = node_q;
    pos_d    = pos_q;
    c_d      = c_q;
    fm_d     = fm_q;
    last_d   = last_q;
    hops_d   = hops_q;
    nvld_d   = nvld_q;
    out_d    = out_q;
    deg_d    = deg_q;
    low_d    = low_q;
    rng_d    = rng_q;
    fail_d   = fail_q;
    pass_d   = pass_q;
    k_d      = k_q;
    eidx_d   = eidx_q;
    pidx_d   = pidx_q;
    blen_d   = blen_q;
    bcode_d  = bcode_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ocode_d  = ocode_q;

    pass_fail = 1'b0;
    miss      = 1'b0;
    miss_fail = fail_q;
    hit       = 1'b0;
    hit_tgt   = 16'd0;
    res       = 16'd0;

    // Byte under test in this pass: as given, then with its case flipped.
    cc     = pass_q ? (c_q ^ fm_q) : c_q;
    hi     = {1'b0, low_q} + {1'b0, deg_q};
    in_rng = (cc >= low_q) && ({1'b0, cc} <= hi);
    ridx   = {1'b0, out_q} + {9'd0, cc - low_q};
    lidx   = {1'b0, out_q} + {9'd0, k_q};

    plen  = pat_rdata[7:0];
    pcode = pat_rdata[23:8];
    pfs   = pat_rdata[24];
    pae   = pat_rdata[25];
    plast = pat_rdata[26];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.data.op == OP_TEXT)) begin
          c_d    = in_i.data.text_byte;
          fm_d   = in_i.data.ignore_case ? fold_mask(in_i.data.text_byte) : 8'd0;
          last_d = in_i.data.last_byte;
          hops_d = '0;
          if (32'(pos_q) < MAX_TEXT_LEN) begin
            pos_d = pos_q + 8'd1;
          end
          nvld_d  = (32'(node_q) < NODE_COUNT);
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        state_d = S_NEV;
      end
      S_NEV: begin
        out_d  = nd[15:0];
        deg_d  = nd[23:16];
        low_d  = nd[31:24];
        rng_d  = nd[32];
        fail_d = nd[49:34];
        miss_fail = nd[49:34];
        if (nd[15:0] == 16'd0) begin
          miss = 1'b1;
        end else if (nd[23:16] == 8'd0) begin
          // Single edge held in the node word itself.
          if ((nd[31:24] == c_q) || ((fm_q != 8'd0) && (nd[31:24] == (c_q ^ fm_q)))) begin
            hit     = 1'b1;
            hit_tgt = nd[15:0];
          end else begin
            miss = 1'b1;
          end
        end else begin
          pass_d  = 1'b0;
          k_d     = 8'd0;
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        if (rng_q) begin
          if (in_rng && (32'(ridx) < EDGE_COUNT)) begin
            eidx_d  = ridx;
            state_d = S_EEV;
          end else begin
            pass_fail = 1'b1;
          end
        end else begin
          if (32'(lidx) < EDGE_COUNT) begin
            eidx_d  = lidx;
            state_d = S_EEV;
          end else begin
            pass_fail = 1'b1;
          end
        end
      end
      S_EEV: begin
        if (rng_q) begin
          if (edge_rdata[15:0] != 16'd0) begin
            hit     = 1'b1;
            hit_tgt = edge_rdata[15:0];
          end else begin
            pass_fail = 1'b1;
          end
        end else if (edge_rdata[23:16] == cc) begin
          // A listed edge that is found ends the search, even with a zero target.
          if (edge_rdata[15:0] != 16'd0) begin
            hit     = 1'b1;
            hit_tgt = edge_rdata[15:0];
          end else begin
            miss = 1'b1;
          end
        end else if (k_q == deg_q) begin
          pass_fail = 1'b1;
        end else begin
          k_d     = k_q + 8'd1;
          state_d = S_ERD;
        end
      end
      S_N2RD: begin
        state_d = S_N2EV;
      end
      S_N2EV: begin
        if (nd[33] && (nd[61:50] != 12'd0)) begin
          pidx_d = {1'b0, nd[61:50]};
          if (32'(nd[61:50]) < PATTERN_COUNT) begin
            state_d = S_PRD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_PRD: begin
        state_d = S_PEV;
      end
      S_PEV: begin
        if (pfs && pae) begin
          if ((plen == pos_q) && last_q) begin
            blen_d[0]  = plen;
            bcode_d[0] = pcode;
          end
        end else if (pfs) begin
          if ((plen == pos_q) && (plen > blen_q[1])) begin
            blen_d[1]  = plen;
            bcode_d[1] = pcode;
          end
        end else if (pae) begin
          if (last_q && (plen > blen_q[2])) begin
            blen_d[2]  = plen;
            bcode_d[2] = pcode;
          end
        end else if (plen > blen_q[3]) begin
          blen_d[3]  = plen;
          bcode_d[3] = pcode;
        end
        pidx_d = pidx_q + 13'd1;
        if (plast || (32'(pidx_q) + 32'd1 >= PATTERN_COUNT)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_PRD;
        end
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || out_o.ready) begin
          priority if (blen_q[0] != 8'd0) res = bcode_q[0];
          else if (blen_q[1] != 8'd0) res = bcode_q[1];
          else if (blen_q[2] != 8'd0) res = bcode_q[2];
          else if (blen_q[3] != 8'd0) res = bcode_q[3];
          else res = 16'd0;
          ovalid_d = 1'b1;
          ocode_d  = res;
          node_d   = 16'd1;
          pos_d    = 8'd0;
          for (int i = 0; i < 4; i++) begin
            blen_d[i]  = 8'd0;
            bcode_d[i] = 16'd0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of one search pass: retry with the other case, or give up on this node.
    if (pass_fail) begin
      if (!pass_q && (fm_q != 8'd0)) begin
        pass_d  = 1'b1;
        k_d     = 8'd0;
        state_d = S_ERD;
      end else begin
        miss = 1'b1;
      end
    end

    // Lookup failed: follow the failure link; skip the byte at no link or hop limit.
    if (miss) begin
      if ((miss_fail == 16'd0) || (32'(hops_q) >= NODE_COUNT)) begin
        state_d = S_DONE;
      end else begin
        node_d  = miss_fail;
        hops_d  = hops_q + 17'd1;
        nvld_d  = (32'(miss_fail) < NODE_COUNT);
        state_d = S_NRD;
      end
    end

    // Consuming move: fetch the target node to see if it ends patterns.
    if (hit) begin
      node_d  = hit_tgt;
      nvld_d  = (32'(hit_tgt) < NODE_COUNT);
      state_d = S_N2RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      node_q   <= 16'd1;
      pos_q    <= 8'd0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        blen_q[i]  <= 8'd0;
        bcode_q[i] <= 16'd0;
      end
    end else begin
      state_q  <= state_d;
      node_q   <= node_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
      blen_q   <= blen_d;
      bcode_q  <= bcode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    fm_q    <= fm_d;
    last_q  <= last_d;
    hops_q  <= hops_d;
    nvld_q  <= nvld_d;
    out_q   <= out_d;
    deg_q   <= deg_d;
    low_q   <= low_d;
    rng_q   <= rng_d;
    fail_q  <= fail_d;
    pass_q  <= pass_d;
    k_q     <= k_d;
    eidx_q  <= eidx_d;
    pidx_q  <= pidx_d;
    ocode_q <= ocode_d;
  end

endmodule

/* tb/tb_aho_corasick_anchored_matcher.sv */
// Self-checking testbench for the anchored Aho-Corasick matcher.
module tb_aho_corasick_anchored_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import acam_pkg::*;

  localparam int unsigned NODES      = 1024;
  localparam int unsigned EDGES      = 4096;
  localparam int unsigned PATTERNS   = 1024;
  localparam int unsigned TEXT_MAX   = 255;
  localparam int unsigned RAND_NODES = 16;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 800;

  // Predicts the match code of every string and checks it against the
  // results that leave the block, oldest first.
  class match_scoreboard;
    logic [61:0] node_mem [NODES];
    logic [23:0] edge_mem [EDGES];
    logic [26:0] pat_mem [PATTERNS];
    int unsigned cur_node;
    int unsigned position;
    int unsigned best_len [4];
    logic [15:0] best_code [4];
    logic [15:0] pending_codes [$];
    int unsigned mismatches;
    int unsigned strings_checked;
    int unsigned text_bytes;

    function new();
      foreach (node_mem[i]) node_mem[i] = '0;
      foreach (edge_mem[i]) edge_mem[i] = '0;
      foreach (pat_mem[i]) pat_mem[i] = '0;
      mismatches = 0;
      strings_checked = 0;
      text_bytes = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      cur_node = 1;
      position = 0;
      foreach (best_len[k]) begin
        best_len[k] = 0;
        best_code[k] = '0;
      end
    endfunction

    function logic [61:0] node_at(int unsigned idx);
      return (idx < NODES) ? node_mem[idx] : '0;
    endfunction

    function int unsigned range_hit(int unsigned base, int unsigned deg, int unsigned low,
                                    int unsigned c);
      int unsigned idx;
      if (c < low || c > low + deg) return 0;
      idx = base + (c - low);
      return (idx < EDGES) ? 32'(edge_mem[idx][15:0]) : 0;
    endfunction

    // Searches the listed edge set in order; the first byte match wins.
    function bit list_hit(int unsigned base, int unsigned deg, int unsigned c,
                          output int unsigned tgt);
      int unsigned idx;
      int unsigned k;
      tgt = 0;
      for (k = 0; k <= deg; k++) begin
        idx = base + k;
        if (idx >= EDGES) return 1'b0;
        if (edge_mem[idx][23:16] == c[7:0]) begin
          tgt = 32'(edge_mem[idx][15:0]);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int unsigned follow_edge(logic [61:0] n, int unsigned c, int unsigned fm);
      int unsigned base;
      int unsigned deg;
      int unsigned low;
      int unsigned t;
      base = 32'(n[15:0]);
      deg = 32'(n[23:16]);
      low = 32'(n[31:24]);
      t = 0;
      if (base == 0) return 0;
      if (deg == 0) begin
        if (low == c) return base;
        if (fm != 0 && low == (c ^ fm)) return base;
        return 0;
      end
      if (n[32]) begin
        t = range_hit(base, deg, low, c);
        if (t == 0 && fm != 0) t = range_hit(base, deg, low, c ^ fm);
        return t;
      end
      if (list_hit(base, deg, c, t)) return t;
      if (fm != 0 && list_hit(base, deg, c ^ fm, t)) return t;
      return 0;
    endfunction

    function void scan_patterns(int unsigned first, bit at_last);
      int unsigned idx;
      int unsigned len;
      logic [26:0] p;
      for (idx = first; idx < PATTERNS; idx++) begin
        p = pat_mem[idx];
        len = 32'(p[7:0]);
        if (p[24] && p[25]) begin
          if (len == position && at_last) begin
            best_len[0] = len;
            best_code[0] = p[23:8];
          end
        end else if (p[24]) begin
          if (len == position && len > best_len[1]) begin
            best_len[1] = len;
            best_code[1] = p[23:8];
          end
        end else if (p[25]) begin
          if (at_last && len > best_len[2]) begin
            best_len[2] = len;
            best_code[2] = p[23:8];
          end
        end else if (len > best_len[3]) begin
          best_len[3] = len;
          best_code[3] = p[23:8];
        end
        if (p[26]) break;
      end
    endfunction

    function void note_input(in_item_t it);
      int unsigned c;
      int unsigned fm;
      int unsigned node;
      int unsigned hops;
      int unsigned nxt;
      int unsigned fail;
      logic [61:0] n;
      logic [15:0] code;
      case (it.op)
        OP_NODE: if (it.addr < NODES) node_mem[it.addr] = it.word[61:0];
        OP_EDGE: if (it.addr < EDGES) edge_mem[it.addr] = it.word[23:0];
        OP_PAT:  if (it.addr < PATTERNS) pat_mem[it.addr] = it.word[26:0];
        default: begin
          text_bytes++;
          c = 32'(it.text_byte);
          fm = 0;
          if (it.ignore_case && ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
            fm = 32;
          node = cur_node;
          nxt = 0;
          hops = 0;
          // Failure hops do not consume the byte; a node without a link,
          // or a looping chain, drops the byte in place.
          while (1) begin
            n = node_at(node);
            nxt = follow_edge(n, c, fm);
            if (nxt != 0) break;
            fail = 32'(n[49:34]);
            if (fail == 0 || hops >= NODES) break;
            node = fail;
            hops++;
          end
          if (position < TEXT_MAX) position++;
          if (nxt != 0) begin
            node = nxt;
            n = node_at(node);
            if (n[33] && n[61:50] != 0) scan_patterns(32'(n[61:50]), it.last_byte);
          end
          cur_node = node & 32'hFFFF;
          if (it.last_byte) begin
            code = '0;
            for (int k = 0; k < 4; k++) begin
              if (best_len[k] != 0) begin
                code = best_code[k];
                break;
              end
            end
            pending_codes.push_back(code);
            restart_walk();
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t r);
      logic [15:0] want;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result match_code=%h", r.match_code);
        return;
      end
      want = pending_codes.pop_front();
      strings_checked++;
      if (r.match_code !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: match_code expected %h actual %h", want, r.match_code);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  acam_in_if  in_if ();
  acam_out_if out_if ();

  aho_corasick_anchored_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  match_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned cycle_count;
  int unsigned edge_ptr;
  int unsigned pat_ptr;
  logic hold_off;
  event start_hold;
  byte unsigned alphabet [6] = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h41, 8'h42};

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // A hard ceiling on the run; only a hung block gets here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing items
  // and the block backs up into its input.
  initial begin
    hold_off = 1'b0;
    forever begin
      @(start_hold);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  // Receiver: results are sampled at the edge, ready is redrawn each cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      out_if.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high so that back-to-back items need no gap.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic send_load(input op_e op, input int unsigned addr, input logic [63:0] w);
    in_item_t it;
    it.op = op;
    it.addr = addr[11:0];
    it.word = w;
    it.text_byte = 8'($urandom_range(255));
    it.ignore_case = 1'($urandom_range(1));
    it.last_byte = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_byte(input byte unsigned c, input bit icase, input bit last);
    in_item_t it;
    it.op = OP_TEXT;
    it.addr = 12'($urandom_range(4095));
    it.word = {$urandom(), $urandom()};
    it.text_byte = c;
    it.ignore_case = icase;
    it.last_byte = last;
    send_item(it);
  endtask

  task automatic send_str(input string s, input bit icase);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], icase, i == s.len() - 1);
  endtask

  // Waits for every string's result; the walk is then idle and the tables
  // may be rewritten.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_codes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] mk_node(int unsigned outp, int unsigned deg, int unsigned low,
                                          bit rng, bit fin, int unsigned fail, int unsigned pat);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    w[15:0] = 16'(outp);
    w[23:16] = 8'(deg);
    w[31:24] = 8'(low);
    w[32] = rng;
    w[33] = fin;
    w[49:34] = 16'(fail);
    w[61:50] = 12'(pat);
    return w;
  endfunction

  function automatic logic [63:0] mk_edge(int unsigned tgt, int unsigned b);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    w[15:0] = 16'(tgt);
    w[23:16] = 8'(b);
    return w;
  endfunction

  function automatic logic [63:0] mk_pat(int unsigned len, int unsigned code, bit st, bit en,
                                         bit lst);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    w[7:0] = 8'(len);
    w[23:8] = 16'(code);
    w[24] = st;
    w[25] = en;
    w[26] = lst;
    return w;
  endfunction

  function automatic byte unsigned pick_char();
    if ($urandom_range(99) < 85) return alphabet[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // Mostly live nodes, with some empty targets and some beyond the table.
  function automatic int unsigned pick_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 12) return $urandom_range(65535, NODES);
    return $urandom_range(RAND_NODES, 1);
  endfunction

  // Random automaton over nodes 1..RAND_NODES. Failure links always point
  // to a lower node, or off the table, so every chain ends.
  task automatic build_automaton();
    int unsigned kind;
    int unsigned deg;
    int unsigned low;
    int unsigned fail;
    int unsigned pat;
    int unsigned run;
    bit fin;
    edge_ptr = 200;
    pat_ptr = 100;
    for (int unsigned i = 1; i <= RAND_NODES; i++) begin
      kind = $urandom_range(2);
      low = 32'(pick_char());
      if (i == 1) fail = 0;
      else if ($urandom_range(19) == 0) fail = $urandom_range(65535, NODES);
      else fail = $urandom_range(i - 1);
      fin = ($urandom_range(99) < 45);
      pat = $urandom_range(4095);
      if (fin) begin
        if ($urandom_range(9) == 0) pat = 0;
        else begin
          pat = pat_ptr;
          run = $urandom_range(3, 1);
          for (int unsigned k = 0; k < run; k++)
            send_load(OP_PAT, pat_ptr + k, mk_pat($urandom_range(6, 1), $urandom_range(65535),
                      1'($urandom_range(1)), 1'($urandom_range(1)), k == run - 1));
          pat_ptr += run;
        end
      end
      if (kind == 0) begin
        send_load(OP_NODE, i, mk_node(pick_target(), 0, low, 1'($urandom_range(1)), fin, fail,
                                      pat));
      end else begin
        if (kind == 1) deg = ($urandom_range(19) == 0) ? 255 : $urandom_range(3, 1);
        else deg = $urandom_range(4, 1);
        if (edge_ptr + deg >= EDGES - 8) edge_ptr = 200;
        for (int unsigned k = 0; k <= deg; k++)
          send_load(OP_EDGE, edge_ptr + k,
                    mk_edge(pick_target(), (kind == 1) ? $urandom_range(255) : 32'(pick_char())));
        send_load(OP_NODE, i, mk_node(edge_ptr, deg, low, kind == 1, fin, fail, pat));
        edge_ptr += deg + 1;
      end
    end
  endtask

  // Strings over the automaton's alphabet, with a few ignored loads mixed
  // in and now and then one longer than the position counter.
  task automatic run_strings(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    bit icase;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1))
          send_load(OP_NODE, $urandom_range(4095, NODES), {$urandom(), $urandom()});
        else
          send_load(OP_PAT, $urandom_range(4095, PATTERNS), {$urandom(), $urandom()});
        continue;
      end
      len = ($urandom_range(199) == 0) ? 260 : $urandom_range(6, 1);
      icase = 1'($urandom_range(1));
      for (int unsigned i = 0; i < len; i++) send_byte(pick_char(), icase, i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    src_idle_pct = 34;
    snk_idle_pct = 83;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-built automaton: range root, single edge, listed edges, a final
    // node with one hit of each kind, a run that falls off the table end,
    // an edge list off the edge table, and a self-looping failure link.
    // Every entry that a string below can reach is written here.
    send_load(OP_NODE, 1, mk_node(100, 2, 8'h61, 1'b1, 1'b0, 0, 0));
    send_load(OP_EDGE, 100, mk_edge(2, 8'h00));
    send_load(OP_EDGE, 101, mk_edge(3, 8'h00));
    send_load(OP_EDGE, 102, mk_edge(0, 8'h00));
    send_load(OP_NODE, 2, mk_node(5, 0, 8'h62, 1'b0, 1'b0, 1, 0));
    send_load(OP_NODE, 3, mk_node(110, 2, 8'h00, 1'b0, 1'b0, 1, 0));
    send_load(OP_EDGE, 110, mk_edge(6, 8'h78));
    send_load(OP_EDGE, 111, mk_edge(7, 8'h59));
    send_load(OP_EDGE, 112, mk_edge(3000, 8'h7A));
    send_load(OP_NODE, 5, mk_node(0, 0, 0, 1'b0, 1'b1, 3, 10));
    send_load(OP_PAT, 10, mk_pat(2, 16'h0011, 1'b1, 1'b1, 1'b0));
    send_load(OP_PAT, 11, mk_pat(2, 16'h0022, 1'b1, 1'b0, 1'b0));
    send_load(OP_PAT, 12, mk_pat(2, 16'h0033, 1'b0, 1'b1, 1'b0));
    send_load(OP_PAT, 13, mk_pat(2, 16'h0044, 1'b0, 1'b0, 1'b1));
    send_load(OP_NODE, 6, mk_node(8, 0, 8'h71, 1'b0, 1'b1, 3, 1020));
    for (int unsigned i = 1020; i < PATTERNS; i++)
      send_load(OP_PAT, i, mk_pat(i - 1018, 16'hA000 + i, 1'b0, 1'b0, 1'b0));
    send_load(OP_NODE, 7, mk_node(4095, 3, 0, 1'b0, 1'b1, 0, 0));
    send_load(OP_EDGE, 4095, mk_edge(2, 8'h30));
    send_load(OP_NODE, 8, mk_node(0, 0, 0, 1'b0, 1'b0, 8, 0));
    send_load(OP_NODE, 4095, mk_node(1, 0, 8'h61, 1'b0, 1'b1, 0, 1));
    send_load(OP_PAT, 2000, mk_pat(1, 16'hFFFF, 1'b0, 1'b0, 1'b1));
    send_str("ab", 0);
    send_str("AB", 1);
    send_str("AB", 0);
    send_str("xab", 0);
    send_str("c", 0);
    send_str("bx", 0);
    send_str("by", 1);
    send_str("bY", 0);
    send_str("bza", 0);
    send_str("bxqa", 0);
    send_str("bYa", 1);
    drain();

    // Three random phases with the idling pattern changing between them.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
      snk_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 34 : 0;
      build_automaton();
      run_strings(100);
      if (ph == 2) begin
        -> start_hold;
        for (int i = 0; i < 40; i++) send_byte(pick_char(), 1'($urandom_range(1)), 1'b1);
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Ran %0d text bytes and checked %0d string results over hand-built and random",
             sb.text_bytes, sb.strings_checked);
    $display("automata, with three idling mixes and one long output stall.");
    if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_codes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/acam_pkg.sv
hdl/acam_in_if.sv
hdl/acam_out_if.sv
hdl/acam_ram.sv
hdl/aho_corasick_anchored_matcher.sv
tb/tb_aho_corasick_anchored_matcher.sv
